// ----- rtl/core/dsss_plcp_framer_scrambler_assert.svh -----
// ----------------------------------------------------------------------------
// DSSS PLCP framer assertion macros
// Concurrent assertion forms for the framer's RTL, used by dpfs_back.
// ----------------------------------------------------------------------------
`ifndef DSSS_PLCP_FRAMER_SCRAMBLER_ASSERT_SVH
`define DSSS_PLCP_FRAMER_SCRAMBLER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DPFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define DPFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dpfs_pkg.sv -----
// ----------------------------------------------------------------------------
// dpfs_pkg
// Types, codes, constants and helper functions of the DSSS PLCP framer.
// ----------------------------------------------------------------------------
package dpfs_pkg;

  localparam int unsigned PKG_MAX_PSDU_BYTES = 4095;
  localparam int unsigned QUEUE_DEPTH        = 4;

  // input item kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // rate_mode codes
  localparam logic [2:0] MODE_L1    = 3'd0;
  localparam logic [2:0] MODE_L2    = 3'd1;
  localparam logic [2:0] MODE_L55   = 3'd2;
  localparam logic [2:0] MODE_L11   = 3'd3;
  localparam logic [2:0] MODE_S2    = 3'd4;
  localparam logic [2:0] MODE_S55   = 3'd5;
  localparam logic [2:0] MODE_S11   = 3'd6;
  localparam logic [2:0] MODE_UNDEF = 3'd7;

  // SIGNAL field codes
  localparam logic [7:0] SIG_1M  = 8'h0A;
  localparam logic [7:0] SIG_2M  = 8'h14;
  localparam logic [7:0] SIG_5M5 = 8'h37;
  localparam logic [7:0] SIG_11M = 8'h6E;

  localparam logic [7:0] SVC_BASE = 8'h04;
  localparam logic [7:0] SVC_EXT  = 8'h84;

  // preamble bytes
  localparam logic [7:0] LONG_FILL   = 8'hFF;
  localparam logic [7:0] LONG_SFD0   = 8'hA0;
  localparam logic [7:0] LONG_SFD1   = 8'hF3;
  localparam logic [7:0] SHORT_FILL  = 8'h00;
  localparam logic [7:0] SHORT_SFD0  = 8'hCF;
  localparam logic [7:0] SHORT_SFD1  = 8'h05;

  localparam logic [6:0] SEED_LONG  = 7'h1B;
  localparam logic [6:0] SEED_SHORT = 7'h6C;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // header geometry: preamble length, then six header bytes
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned PRE_LONG_N  = 18;
  localparam int unsigned PRE_SHORT_N = 9;
  localparam int unsigned HDR_TAIL_N  = 6;

  // floor(x/11) = (x * RECIP_11) >> RECIP_SHIFT, exact for x < 233016
  localparam logic [17:0] RECIP_11    = 18'd190651;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = 18;

  // one queued request from front to back
  typedef struct packed {
    logic       is_start;
    logic [2:0] mode;
    logic [7:0] data;
    logic       fend;
  } cmd_t;

  typedef struct packed {
    logic [6:0] state;
    logic [7:0] data;
  } scr_res_t;

  // x^7+x^4+1 scrambler over one byte, bit 0 first
  function automatic scr_res_t scramble_byte(input logic [6:0] s_in, input logic [7:0] b);
    scr_res_t   res;
    logic [6:0] s;
    logic       bit_v;
    s = s_in;
    res.data = '0;
    for (int j = 0; j < 8; j++) begin
      bit_v       = b[j] ^ s[3] ^ s[6];
      res.data[j] = bit_v;
      s           = {s[5:0], bit_v};
    end
    res.state = s;
    return res;
  endfunction

  // CRC-16 CCITT update over one byte, bit 0 first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/dpfs_front.sv -----
// ----------------------------------------------------------------------------
// dpfs_front
// Accepts input items, resolves rate and length, drops stray bytes.
// ----------------------------------------------------------------------------
module dpfs_front import dpfs_pkg::*; #(
  parameter int unsigned MAX_PSDU_BYTES = PKG_MAX_PSDU_BYTES,
  localparam int unsigned LEN_W = $clog2(MAX_PSDU_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [11:0]      in_psdu_length,
  input  logic [7:0]       in_payload_byte,
  input  logic [2:0]       rate_mode,
  input  logic             q_ready,
  output logic             q_push,
  output cmd_t             q_cmd,
  output logic [LEN_W-1:0] q_len
);

  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] len_sat;
  logic             accept;
  logic             is_start;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign is_start = (in_kind == KIND_START);

  always_comb begin
    if (32'(in_psdu_length) > MAX_PSDU_BYTES) len_sat = LEN_W'(MAX_PSDU_BYTES);
    else                                       len_sat = LEN_W'(in_psdu_length);
  end

  assign q_cmd.is_start = is_start;
  assign q_cmd.mode     = (rate_mode == MODE_UNDEF) ? MODE_L1 : rate_mode;
  assign q_cmd.data     = in_payload_byte;
  assign q_cmd.fend     = (rem_r == LEN_W'(1));
  assign q_len          = len_sat;

  // bytes past the announced length never reach the queue
  assign q_push = accept && (is_start || (rem_r != '0));

  always_comb begin
    rem_nxt = rem_r;
    if (accept) begin
      if (is_start)          rem_nxt = len_sat;
      else if (rem_r != '0)  rem_nxt = rem_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- rtl/core/dpfs_queue.sv -----
// ----------------------------------------------------------------------------
// dpfs_queue
// Small register FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module dpfs_queue import dpfs_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/dpfs_back.sv -----
// ----------------------------------------------------------------------------
// dpfs_back
// Emits preamble, header with CRC and payload, scrambled, one byte a cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
`include "dsss_plcp_framer_scrambler_assert.svh"

module dpfs_back import dpfs_pkg::*; #(
  parameter int unsigned MAX_PSDU_BYTES = PKG_MAX_PSDU_BYTES,
  localparam int unsigned LEN_W = $clog2(MAX_PSDU_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  input  logic [LEN_W-1:0] q_len,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  output logic             out_frame_end
);

  localparam int unsigned X_W = LEN_W + 5;
  localparam int unsigned P_W = X_W + RECIP_W;
  localparam int unsigned Q_W = P_W - RECIP_SHIFT;
  localparam int unsigned D_W = X_W + 1;

  // header offsets after the preamble
  localparam logic [IDX_W-1:0] H_SIGNAL  = IDX_W'(0);
  localparam logic [IDX_W-1:0] H_SERVICE = IDX_W'(1);
  localparam logic [IDX_W-1:0] H_LEN_LO  = IDX_W'(2);
  localparam logic [IDX_W-1:0] H_LEN_HI  = IDX_W'(3);
  localparam logic [IDX_W-1:0] H_CRC_LO  = IDX_W'(4);

  logic             hdr_r;
  logic [IDX_W-1:0] idx_r;
  logic             long_r;
  logic [2:0]       mode_r;
  logic [LEN_W-1:0] len_r;
  logic [6:0]       scr_r;
  logic [15:0]      crc_r;
  logic [Q_W-1:0]   q_r;
  logic [15:0]      us_r;
  logic             svc_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_fend_r;

  logic             load, pop_start, pop_long, hdr_last, crc_upd;
  logic [IDX_W-1:0] pre_n, hdr_n_last, h;
  logic [7:0]       sig, hdr_byte, src_byte;
  logic [6:0]       scr_in;
  scr_res_t         scr;
  logic [X_W-1:0]   div_x;
  logic [P_W-1:0]   prod;
  logic [D_W-1:0]   ext_diff;
  logic [31:0]      len8, len4, q32;

  assign load      = !out_valid_r || out_ready;
  assign q_pop     = load && !hdr_r && q_valid;
  assign pop_start = q_pop && q_cmd.is_start;
  assign pop_long  = (q_cmd.mode <= MODE_L11);

  assign pre_n      = long_r ? IDX_W'(PRE_LONG_N) : IDX_W'(PRE_SHORT_N);
  assign hdr_n_last = pre_n + IDX_W'(HDR_TAIL_N - 1);
  assign h          = idx_r - pre_n;
  assign hdr_last   = (idx_r == hdr_n_last);
  assign crc_upd    = hdr_r && load && (idx_r >= pre_n) && (h < H_CRC_LO);

  always_comb begin
    case (mode_r) inside
      MODE_L1:          sig = SIG_1M;
      MODE_L2, MODE_S2:   sig = SIG_2M;
      MODE_L55, MODE_S55: sig = SIG_5M5;
      default:          sig = SIG_11M;
    endcase
  end

  always_comb begin
    if (idx_r < pre_n - IDX_W'(2))      hdr_byte = long_r ? LONG_FILL : SHORT_FILL;
    else if (idx_r == pre_n - IDX_W'(2)) hdr_byte = long_r ? LONG_SFD0 : SHORT_SFD0;
    else if (idx_r == pre_n - IDX_W'(1)) hdr_byte = long_r ? LONG_SFD1 : SHORT_SFD1;
    else begin
      case (h)
        H_SIGNAL:  hdr_byte = sig;
        H_SERVICE: hdr_byte = svc_r ? SVC_EXT : SVC_BASE;
        H_LEN_LO:  hdr_byte = us_r[7:0];
        H_LEN_HI:  hdr_byte = us_r[15:8];
        H_CRC_LO:  hdr_byte = ~crc_r[7:0];
        default:   hdr_byte = ~crc_r[15:8];
      endcase
    end
  end

  always_comb begin
    if (hdr_r)          src_byte = hdr_byte;
    else if (pop_start) src_byte = pop_long ? LONG_FILL : SHORT_FILL;
    else                src_byte = q_cmd.data;
  end

  assign scr_in = pop_start ? (pop_long ? SEED_LONG : SEED_SHORT) : scr_r;
  assign scr    = scramble_byte(scr_in, src_byte);

  // LENGTH in microseconds: reciprocal multiply, then a registered fix-up stage
  assign div_x = ((mode_r == MODE_L55) || (mode_r == MODE_S55))
               ? ({len_r, 4'b0000} + X_W'(10))
               : ({1'b0, len_r, 3'b000} + X_W'(10));
  assign prod  = P_W'(div_x) * P_W'(RECIP_11);

  assign ext_diff = (D_W'(q_r) << 3) + (D_W'(q_r) << 1) + D_W'(q_r)
                  - (D_W'(len_r) << 3);
  assign len8 = 32'(len_r) << 3;
  assign len4 = 32'(len_r) << 2;
  assign q32  = 32'(q_r);

  always_ff @(posedge clk) begin
    q_r   <= prod[P_W-1:RECIP_SHIFT];
    svc_r <= ((mode_r == MODE_L11) || (mode_r == MODE_S11)) && (ext_diff >= D_W'(8));
    case (mode_r) inside
      MODE_L1:          us_r <= len8[15:0];
      MODE_L2, MODE_S2: us_r <= len4[15:0];
      default:          us_r <= q32[15:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (crc_upd)   crc_r <= crc_byte(crc_r, hdr_byte);
    if (pop_start) begin
      crc_r  <= CRC_INIT;
      mode_r <= q_cmd.mode;
      len_r  <= q_len;
      long_r <= pop_long;
    end
    if (load && (hdr_r || q_pop)) begin
      out_byte_r <= scr.data;
      if (hdr_r) begin
        out_last_r <= hdr_last;
        out_fend_r <= hdr_last && (len_r == '0);
      end else begin
        // a start opens the preamble; only a payload byte ends its own run
        out_last_r <= !q_cmd.is_start;
        out_fend_r <= q_cmd.is_start ? 1'b0 : q_cmd.fend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r       <= 1'b0;
      idx_r       <= '0;
      scr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) out_valid_r <= hdr_r || q_pop;
      if (load && (hdr_r || q_pop)) scr_r <= scr.state;
      if (hdr_r && load) begin
        idx_r <= idx_r + IDX_W'(1);
        if (hdr_last) hdr_r <= 1'b0;
      end
      if (pop_start) begin
        hdr_r <= 1'b1;
        idx_r <= IDX_W'(1);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_frame_end   = out_fend_r;

  `DPFS_ASSERT_IMPL(a_fend_is_last, clk, rst_n, out_valid_r && out_fend_r, out_last_r, "frame end not marked last")
  `DPFS_ASSERT_NEXT(a_hdr_close, clk, rst_n, hdr_r && load && hdr_last, !hdr_r && out_valid_r && out_last_r, "header did not close on last byte")
  `DPFS_ASSERT_IMPL(a_idx_bound, clk, rst_n, hdr_r, (idx_r <= hdr_n_last) && (idx_r != '0), "header index out of range")
  `DPFS_ASSERT_NEXT(a_start_opens, clk, rst_n, pop_start, hdr_r && out_valid_r && !out_last_r, "start did not open header")

endmodule

// ----- rtl/core/dsss_plcp_framer_scrambler.sv -----
// ----------------------------------------------------------------------------
// dsss_plcp_framer_scrambler
// 802.11b DSSS PLCP framer: preamble, header with CRC-16, scrambled payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): a start request (in_kind 0) carries the
//   PSDU length and opens a frame; payload requests (in_kind 1) carry a byte.
//   Output channel (out_valid/out_ready): scrambled bytes, bit 0 first on air,
//   with out_last_of_run on the last byte caused by a request and
//   out_frame_end on the final byte of the PPDU.
//   cfg_wr_en/cfg_wr_data write rate_mode; write only while the block is idle.
// Data path and throughput:
//   A request goes through a 4-deep queue and the output register before its
//   first byte is on the output. A payload request emits one byte; a start
//   request emits 24 bytes (long) or 15 bytes (short) at one byte per cycle
//   while out_ready is high, set by the single output register.
//   Input keeps flowing during a header until the queue fills.
// Reset: no frame open, rate_mode 0, queue and output register empty.
// Stall: when out_ready is low the output holds; the queue absorbs up to 4
//   requests, then in_ready drops. Bytes outside a frame are taken and dropped.
// ----------------------------------------------------------------------------
module dsss_plcp_framer_scrambler import dpfs_pkg::*; #(
  parameter int unsigned MAX_PSDU_BYTES = PKG_MAX_PSDU_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [11:0] in_psdu_length,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_frame_end,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);

  localparam int unsigned LEN_W = $clog2(MAX_PSDU_BYTES + 1);
  localparam int unsigned Q_W   = $bits(cmd_t) + LEN_W;

  logic [2:0]       rate_mode_r;

  // front -> queue
  logic             f_push, q_ready;
  cmd_t             f_cmd;
  logic [LEN_W-1:0] f_len;

  // queue -> back
  logic             b_pop, b_valid;
  logic [Q_W-1:0]   b_data;
  cmd_t             b_cmd;
  logic [LEN_W-1:0] b_len;

  // rate register, sampled by the front at each start request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_mode_r <= MODE_L1;
    end else if (cfg_wr_en) begin
      rate_mode_r <= cfg_wr_data;
    end
  end

  dpfs_front #(.MAX_PSDU_BYTES(MAX_PSDU_BYTES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_psdu_length  (in_psdu_length),
    .in_payload_byte (in_payload_byte),
    .rate_mode       (rate_mode_r),
    .q_ready         (q_ready),
    .q_push          (f_push),
    .q_cmd           (f_cmd),
    .q_len           (f_len)
  );

  dpfs_queue #(.W(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  ({f_cmd, f_len}),
    .push_ready (q_ready),
    .pop        (b_pop),
    .pop_valid  (b_valid),
    .pop_data   (b_data)
  );

  assign {b_cmd, b_len} = b_data;

  dpfs_back #(.MAX_PSDU_BYTES(MAX_PSDU_BYTES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (b_valid),
    .q_cmd           (b_cmd),
    .q_len           (b_len),
    .q_pop           (b_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule
